>>> sv/exrzip_pkg.sv
// Shared constants and types for the EXR ZIP predictor and interleave block.
`timescale 1ns / 1ps

package exrzip_pkg;

    localparam int MAX_BLOCK_BYTES = 65536;
    localparam int STORE_DEPTH     = (MAX_BLOCK_BYTES + 1) / 2;
    localparam int LEN_W           = 17;
    localparam int POS_W           = $clog2(MAX_BLOCK_BYTES);
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [7:0] BIAS = 8'd128;

    localparam logic [PADDR_W-1:0] ADDR_BLOCK_LENGTH = PADDR_W'(0);

    // Block configuration as seen by the datapath.
    typedef struct packed {
        logic [POS_W-1:0] len_m1;   // effective block length minus one
        logic             restart;  // a register write abandons the current block
    } t_cfg;

    // One reconstructed byte handed to the output stage.
    typedef struct packed {
        logic       load;    // the byte produces results and enters the output stage
        logic       single;  // one-byte block
        logic       last;    // final byte of the block
        logic [1:0] cnt;     // number of results, 1 to 3
        logic [7:0] value;   // reconstructed byte
    } t_job;

endpackage

>>> sv/exrzip_in_if.sv
// Input channel: one inflated byte per request.
`timescale 1ns / 1ps

interface exrzip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

>>> sv/exrzip_out_if.sv
// Output channel: one interleaved byte per request.
`timescale 1ns / 1ps

interface exrzip_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;

    modport source (output valid, output out_byte, output block_end, input ready);
    modport sink (input valid, input out_byte, input block_end, output ready);
endinterface

>>> sv/exrzip_cfg.sv
// APB register for the block length, with the effective length held ready for the datapath.
`timescale 1ns / 1ps

module exrzip_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [exrzip_pkg::PADDR_W-1:0] paddr,
    input  logic [exrzip_pkg::PDATA_W-1:0] pwdata,
    output logic [exrzip_pkg::PDATA_W-1:0] prdata,
    output logic                           pready,
    output exrzip_pkg::t_cfg               o_cfg
);
    import exrzip_pkg::*;

    logic [LEN_W-1:0] r_block_length;
    logic [LEN_W-1:0] n_block_length;
    logic [POS_W-1:0] r_len_m1;
    logic [POS_W-1:0] n_len_m1;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_BLOCK_LENGTH);
    assign n_block_length = pwdata[LEN_W-1:0];

    // Zero counts as one byte; anything beyond MAX_BLOCK_BYTES saturates.
    always_comb begin
        if (n_block_length == '0) begin
            n_len_m1 = '0;
        end else if (n_block_length > LEN_W'(MAX_BLOCK_BYTES)) begin
            n_len_m1 = POS_W'(MAX_BLOCK_BYTES - 1);
        end else begin
            n_len_m1 = POS_W'(n_block_length - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= LEN_W'(1);
            r_len_m1       <= '0;
        end else begin
            if (wr_hit) begin
                r_block_length <= n_block_length;
                r_len_m1       <= n_len_m1;
            end
        end
    end

    always_comb begin
        if (paddr == ADDR_BLOCK_LENGTH) begin
            prdata = PDATA_W'(r_block_length);
        end else begin
            prdata = '0;
        end
    end

    // The position returns to zero at the same edge that takes the new length.
    assign o_cfg.len_m1  = r_len_m1;
    assign o_cfg.restart = wr_hit;
endmodule

>>> sv/exrzip_recon.sv
// Predictor reconstruction, byte position tracking and the half-block store.
`timescale 1ns / 1ps

module exrzip_recon (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  exrzip_pkg::t_cfg              i_cfg,
    input  logic                          i_stage_free,
    exrzip_in_if.sink                     i_in,
    output exrzip_pkg::t_job              o_job,
    output logic [7:0]                    o_first,
    output logic [7:0]                    o_tail
);
    import exrzip_pkg::*;

    logic [7:0]       store [STORE_DEPTH];
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_prev;
    logic [7:0]       r_first;
    logic [7:0]       r_tail;

    logic [POS_W-1:0] half;
    logic [POS_W-1:0] rd_idx;
    logic [7:0]       value;
    logic             first_half;
    logic             single;
    logic             last;
    logic             odd_len;
    logic             produces;
    logic             accept;

    assign half       = (i_cfg.len_m1 >> 1) + POS_W'(1);
    assign rd_idx     = r_pos - half;
    assign single     = (i_cfg.len_m1 == '0);
    assign odd_len    = ~i_cfg.len_m1[0];
    assign last       = (r_pos == i_cfg.len_m1);
    assign first_half = (r_pos < half);
    assign produces   = !first_half || single;
    assign value      = (r_pos == '0) ? i_in.data_byte : r_prev + i_in.data_byte - BIAS;

    // Bytes of the first half produce nothing (unless the block is one byte) and never wait on the output stage.
    assign i_in.ready = !produces || i_stage_free;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= '0;
        end else if (i_cfg.restart) begin
            r_pos <= '0;
        end else if (accept) begin
            r_prev <= value;
            r_pos  <= last ? '0 : r_pos + POS_W'(1);
        end
    end

    // For a second-half byte, every read address was written by an earlier byte of the same block.
    always_ff @(posedge i_clk) begin
        if (accept && first_half) begin
            store[r_pos[ADDR_W-1:0]] <= value;
        end
        if (accept && produces) begin
            r_first <= store[rd_idx[ADDR_W-1:0]];
            r_tail  <= store[i_cfg.len_m1[ADDR_W:1]];
        end
    end

    assign o_job.load   = accept && produces;
    assign o_job.single = single;
    assign o_job.last   = last;
    assign o_job.cnt    = single ? 2'd1 : ((last && odd_len) ? 2'd3 : 2'd2);
    assign o_job.value  = value;
    assign o_first      = r_first;
    assign o_tail       = r_tail;
endmodule

>>> sv/exrzip_emit.sv
// Output stage: holds one reconstructed byte and sends its one to three results in order.
`timescale 1ns / 1ps

module exrzip_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  exrzip_pkg::t_job i_job,
    input  logic [7:0]       i_first,
    input  logic [7:0]       i_tail,
    output logic             o_stage_free,
    exrzip_out_if.source     o_out
);
    import exrzip_pkg::*;

    logic       r_busy;
    logic [1:0] r_k;
    logic [1:0] r_cnt;
    logic       r_single;
    logic       r_last;
    logic [7:0] r_value;
    logic       final_result;
    logic       send;

    assign final_result = (r_k == r_cnt - 2'd1);
    assign send         = o_out.valid && o_out.ready;
    assign o_stage_free = !r_busy || (send && final_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_job.load) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (send) begin
            r_busy <= !final_result;
            r_k    <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.load) begin
            r_cnt    <= i_job.cnt;
            r_single <= i_job.single;
            r_last   <= i_job.last;
            r_value  <= i_job.value;
        end
    end

    // A pair is the stored byte, then the new one; an odd block ends with the middle byte.
    always_comb begin
        if (r_single) begin
            o_out.out_byte = r_value;
        end else begin
            case (r_k)
                2'd0:    o_out.out_byte = i_first;
                2'd1:    o_out.out_byte = r_value;
                default: o_out.out_byte = i_tail;
            endcase
        end
    end

    assign o_out.valid     = r_busy;
    assign o_out.block_end = r_last && final_result;
endmodule

>>> sv/exr_zip_predictor_interleave_top.sv
// Top level of the EXR ZIP predictor and byte interleave block.
`timescale 1ns / 1ps
// The first result of a byte appears in the cycle after its request is accepted.
// First-half bytes are taken one per cycle; each second-half byte holds the
// single output register for two results (three on the last byte of an odd block),
// so in the second half the one-byte output channel sets the sustained input rate.
// Reset (synchronous, active low) sets the block length to one and the position to zero;
// the half-block store is not cleared, since every entry whose value is used is written before it is read.

module exr_zip_predictor_interleave_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    exrzip_in_if.sink                      i_in,
    exrzip_out_if.source                   o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [exrzip_pkg::PADDR_W-1:0] paddr,
    input  logic [exrzip_pkg::PDATA_W-1:0] pwdata,
    output logic [exrzip_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);
    import exrzip_pkg::*;

    t_cfg       cfg;
    t_job       job;
    logic [7:0] first_byte;
    logic [7:0] tail_byte;
    logic       stage_free;

    // The register write also restarts the block at its first byte.
    exrzip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Undoes the predictor, writes the first half into the store and reads the
    // partner bytes for the second half in the same cycle the request is accepted.
    exrzip_recon u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_stage_free (stage_free),
        .i_in         (i_in),
        .o_job        (job),
        .o_first      (first_byte),
        .o_tail       (tail_byte)
    );

    // Sends the interleaved results; it frees up in the cycle its final result goes out,
    // so the next byte is taken without a bubble.
    exrzip_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_first      (first_byte),
        .i_tail       (tail_byte),
        .o_stage_free (stage_free),
        .o_out        (o_out)
    );
endmodule
